>>> src/agcd_pkg.sv
// agcd_pkg: shared types and codes for the ack-gated command dispatcher.
// No dependencies.
package agcd_pkg;
	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_RESP = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [1:0] ST_TX     = 2'd0;
	localparam logic [1:0] ST_ACK    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;
	localparam logic [1:0] ST_DROP   = 2'd3;

	localparam logic [7:0] TIMEOUT_RESET = 8'd10;

	typedef struct packed {
		logic [3:0]  length;
		logic [7:0]  command;
	} hdr_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (len > 4'(b)) m[8*b +: 8] = 8'hFF;
		end
		return m;
	endfunction
endpackage

>>> src/agcd_match.sv
// agcd_match: compare unit for one history entry against a response frame.
// Depends on agcd_pkg.
module agcd_match (
	input  logic             entry_acked,
	input  agcd_pkg::hdr_t   entry_hdr,
	input  logic [63:0]      entry_payload,
	input  agcd_pkg::hdr_t   resp_hdr,
	input  logic [63:0]      resp_payload,
	output logic             hit
);
	assign hit = !entry_acked && (entry_hdr == resp_hdr) &&
		(((entry_payload ^ resp_payload) & agcd_pkg::byte_mask(resp_hdr.length)) == 64'd0);
endmodule

>>> src/ack_gated_command_dispatcher.sv
// ack_gated_command_dispatcher: stop-and-wait send gate with wait queue and history.
// Depends on agcd_pkg and agcd_match.
//
// channel   | direction | signals
// command   | in        | start, kind, command, length, payload, tick_now (busy is out)
// result    | out       | strobe, status, tx_command, tx_length, tx_payload, ack_latency, last
// config    | in        | cfg_we, cfg_data (ack_timeout)
//
// A command passes S_NEWEST and S_DECIDE; a tick S_NEWEST and S_REL_CHK, then
// S_REL_RD and S_REL_TX when it releases a frame. A response scans the history
// from the newest entry: each entry is read in S_SCAN_RD and compared in S_SCAN
// in the shared match unit. Memory reads are registered.
// Reset clears pointers, counts and ack bits and sets the timeout to 10.
// Results cannot be stalled; busy stays high until the last result is driven.
module ack_gated_command_dispatcher #(
	parameter int QUEUE_DEPTH   = 256,
	parameter int HISTORY_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  command,
	input  logic [3:0]  length,
	input  logic [63:0] payload,
	input  logic [31:0] tick_now,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [7:0]  tx_command,
	output logic [3:0]  tx_length,
	output logic [63:0] tx_payload,
	output logic [31:0] ack_latency,
	output logic        last
);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int HCW = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_NEWEST, S_DECIDE, S_SCAN_RD, S_SCAN, S_REL_CHK, S_REL_RD, S_REL_TX
	} state_t;

	state_t state_q;
	logic [7:0]  timeout_q;
	logic [31:0] tick_q;
	logic [QW-1:0] qhead_q;
	logic [QCW-1:0] qcount_q;
	logic [HW-1:0] hwp_q;
	logic [HCW-1:0] hcount_q;
	logic [HISTORY_DEPTH-1:0] hacked_q;

	logic [1:0]  kind_q;
	agcd_pkg::hdr_t hdr_q;
	logic [63:0] pay_q;
	logic        acked_rel_q;
	logic [HCW-1:0] scan_j_q;
	logic [HW-1:0]  scan_i_q;

	agcd_pkg::hdr_t wq_hdr_mem [QUEUE_DEPTH];
	logic [63:0]    wq_pay_mem [QUEUE_DEPTH];
	agcd_pkg::hdr_t h_hdr_mem  [HISTORY_DEPTH];
	logic [63:0]    h_pay_mem  [HISTORY_DEPTH];
	logic [31:0]    h_tick_mem [HISTORY_DEPTH];

	agcd_pkg::hdr_t wq_hdr_rd_q, h_hdr_rd_q;
	logic [63:0]    wq_pay_rd_q, h_pay_rd_q;
	logic [31:0]    h_tick_rd_q;
	logic           h_acked_rd_q;

	logic [QW-1:0] wq_raddr, wq_waddr;
	logic [QCW:0]  wq_sum;
	logic          wq_we;
	logic [HW-1:0] h_raddr;
	logic          h_we;
	agcd_pkg::hdr_t h_whdr;
	logic [63:0]    h_wpay;
	logic [HW-1:0]  newest;
	logic           hit;
	logic           last_ok;
	logic [31:0]    lat;

	assign newest = (hwp_q == '0) ? HW'(HISTORY_DEPTH - 1) : hwp_q - 1'b1;
	assign lat = tick_q - h_tick_rd_q;
	// newest entry read in h_*_rd_q when evaluated
	assign last_ok = (hcount_q == '0) || h_acked_rd_q ||
		(lat >= {24'd0, timeout_q});

	agcd_match u_match (
		.entry_acked(h_acked_rd_q), .entry_hdr(h_hdr_rd_q), .entry_payload(h_pay_rd_q),
		.resp_hdr(hdr_q), .resp_payload(pay_q), .hit(hit)
	);

	always_comb begin
		wq_sum = (QCW+1)'(qhead_q) + (QCW+1)'(qcount_q);
		wq_waddr = (wq_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
			QW'(wq_sum - (QCW+1)'(QUEUE_DEPTH)) : QW'(wq_sum);
		wq_raddr = qhead_q;
		wq_we = 1'b0;
		h_we = 1'b0;
		h_whdr = hdr_q;
		h_wpay = pay_q;
		h_raddr = newest;
		unique case (state_q)
			S_DECIDE: begin
				if (kind_q == agcd_pkg::KIND_CMD) begin
					if (qcount_q == '0 && last_ok) h_we = 1'b1;
					else if (qcount_q != QCW'(QUEUE_DEPTH)) wq_we = 1'b1;
				end
			end
			S_SCAN_RD, S_SCAN: h_raddr = scan_i_q;
			S_REL_TX: begin
				h_we = 1'b1;
				h_whdr = wq_hdr_rd_q;
				h_wpay = wq_pay_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wq_we) begin
			wq_hdr_mem[wq_waddr] <= hdr_q;
			wq_pay_mem[wq_waddr] <= pay_q;
		end
		wq_hdr_rd_q <= wq_hdr_mem[wq_raddr];
		wq_pay_rd_q <= wq_pay_mem[wq_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			h_hdr_mem[hwp_q]  <= h_whdr;
			h_pay_mem[hwp_q]  <= h_wpay;
			h_tick_mem[hwp_q] <= tick_q;
		end
		h_hdr_rd_q  <= h_hdr_mem[h_raddr];
		h_pay_rd_q  <= h_pay_mem[h_raddr];
		h_tick_rd_q <= h_tick_mem[h_raddr];
		h_acked_rd_q <= hacked_q[h_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			timeout_q <= agcd_pkg::TIMEOUT_RESET;
			tick_q <= '0;
			qhead_q <= '0;
			qcount_q <= '0;
			hwp_q <= '0;
			hcount_q <= '0;
			hacked_q <= '0;
			strobe <= 1'b0;
			status <= '0;
			last <= 1'b0;
			ack_latency <= '0;
			tx_command <= '0;
			tx_length <= '0;
			tx_payload <= '0;
			kind_q <= '0;
			hdr_q <= '0;
			pay_q <= '0;
			acked_rel_q <= 1'b0;
			scan_j_q <= '0;
			scan_i_q <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_we) timeout_q <= cfg_data;
			if (h_we) begin
				hacked_q[hwp_q] <= 1'b0;
				hwp_q <= (hwp_q == HW'(HISTORY_DEPTH - 1)) ? '0 : hwp_q + 1'b1;
				if (hcount_q != HCW'(HISTORY_DEPTH)) hcount_q <= hcount_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						hdr_q <= '{length: length, command: command};
						pay_q <= payload;
						acked_rel_q <= 1'b0;
						unique case (kind)
							agcd_pkg::KIND_CMD: state_q <= S_NEWEST;
							agcd_pkg::KIND_RESP: begin
								scan_j_q <= '0;
								scan_i_q <= newest;
								state_q <= S_SCAN_RD;
							end
							agcd_pkg::KIND_TICK: begin
								tick_q <= tick_now;
								state_q <= S_NEWEST;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_NEWEST: state_q <= (kind_q == agcd_pkg::KIND_CMD) ? S_DECIDE : S_REL_CHK;
				S_DECIDE: begin
					state_q <= S_IDLE;
					tx_command <= hdr_q.command;
					tx_length <= hdr_q.length;
					tx_payload <= pay_q;
					ack_latency <= '0;
					last <= 1'b1;
					if (qcount_q == '0 && last_ok) begin
						strobe <= 1'b1;
						status <= agcd_pkg::ST_TX;
					end else if (qcount_q != QCW'(QUEUE_DEPTH)) begin
						qcount_q <= qcount_q + 1'b1;
					end else begin
						strobe <= 1'b1;
						status <= agcd_pkg::ST_DROP;
					end
				end
				S_SCAN_RD: begin
					if (scan_j_q == hcount_q) begin
						strobe <= 1'b1;
						status <= agcd_pkg::ST_NOMATCH;
						tx_command <= hdr_q.command;
						tx_length <= hdr_q.length;
						tx_payload <= pay_q;
						ack_latency <= '0;
						last <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						// ack is driven from S_REL_CHK once the release is known
						hacked_q[scan_i_q] <= 1'b1;
						tx_command <= hdr_q.command;
						tx_length <= hdr_q.length;
						tx_payload <= pay_q;
						ack_latency <= lat;
						acked_rel_q <= 1'b1;
						state_q <= S_NEWEST;
					end else begin
						scan_j_q <= scan_j_q + 1'b1;
						scan_i_q <= (scan_i_q == '0) ? HW'(HISTORY_DEPTH - 1) : scan_i_q - 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_REL_CHK: begin
					if (acked_rel_q) begin
						strobe <= 1'b1;
						status <= agcd_pkg::ST_ACK;
					end
					if (qcount_q != '0 && last_ok) begin
						last <= 1'b0;
						state_q <= S_REL_RD;
					end else begin
						last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_REL_RD: state_q <= S_REL_TX;
				S_REL_TX: begin
					strobe <= 1'b1;
					status <= agcd_pkg::ST_TX;
					tx_command <= wq_hdr_rd_q.command;
					tx_length <= wq_hdr_rd_q.length;
					tx_payload <= wq_pay_rd_q;
					ack_latency <= '0;
					last <= 1'b1;
					qhead_q <= (qhead_q == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + 1'b1;
					qcount_q <= qcount_q - 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

>>> src/agcd_checker.sv
// agcd_checker: port-level assertions for ack_gated_command_dispatcher, with bind.
// Depends on agcd_pkg.
module agcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [1:0] status,
	input logic [31:0] ack_latency,
	input logic       last
);
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy) else $error("idle with results pending");
	a_lat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != agcd_pkg::ST_ACK) |-> ack_latency == 32'd0)
		else $error("latency on non-ack result");
	a_only_ack_leads: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> status == agcd_pkg::ST_ACK)
		else $error("non-ack result not last");
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == agcd_pkg::ST_DROP) |-> last) else $error("drop not last");
	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == agcd_pkg::ST_NOMATCH) |-> last)
		else $error("unmatched response not last");
endmodule

bind ack_gated_command_dispatcher agcd_checker u_agcd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.status(status), .ack_latency(ack_latency), .last(last)
);

>>> test/ack_gated_command_dispatcher_tb.sv
// Testbench for ack_gated_command_dispatcher: drives commands, responses and ticks,
// predicts every result with its own model of the queue and history, checks each strobe.
// Depends on agcd_pkg and the dispatcher RTL.
`timescale 1ns / 100ps

module ack_gated_command_dispatcher_tb;
	typedef struct {
		logic [1:0]  st;
		logic [7:0]  cmd;
		logic [3:0]  len;
		logic [63:0] pl;
		logic [31:0] lat;
		logic        lst;
	} frame_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [7:0]  command;
	logic [3:0]  length;
	logic [63:0] payload;
	logic [31:0] tick_now;
	logic        cfg_we;
	logic [7:0]  cfg_data;
	logic        strobe;
	logic [1:0]  status;
	logic [7:0]  tx_command;
	logic [3:0]  tx_length;
	logic [63:0] tx_payload;
	logic [31:0] ack_latency;
	logic        last;

	// predictor state
	logic [7:0]  timeout_q;
	logic [31:0] now_q;
	agcd_pkg::hdr_t wq_hdr [256];
	logic [63:0] wq_pl  [256];
	logic [7:0]  wq_head;
	int          wq_count;
	agcd_pkg::hdr_t hist_hdr [16];
	logic [63:0] hist_pl    [16];
	logic [31:0] hist_sent  [16];
	logic        hist_acked [16];
	logic [3:0]  hist_wp;
	int          hist_count;

	frame_res_t expected_results[$];
	frame_res_t step_results[$];
	int         mismatches;

	ack_gated_command_dispatcher dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.command(command), .length(length), .payload(payload), .tick_now(tick_now),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .strobe(strobe), .status(status),
		.tx_command(tx_command), .tx_length(tx_length), .tx_payload(tx_payload),
		.ack_latency(ack_latency), .last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20_000_000;
		$display("ack_gated_command_dispatcher test failed");
		$finish;
	end

	function automatic bit newest_clear();
		logic [3:0] i;
		logic [31:0] age;
		if (hist_count == 0) return 1'b1;
		i = hist_wp - 4'd1;
		age = now_q - hist_sent[i];
		return hist_acked[i] || age >= {24'd0, timeout_q};
	endfunction

	function automatic void add_result(logic [1:0] st, agcd_pkg::hdr_t h, logic [63:0] pl,
			logic [31:0] lat);
		frame_res_t r;
		r.st = st;
		r.cmd = h.command;
		r.len = h.length;
		r.pl = pl;
		r.lat = lat;
		r.lst = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void send_frame(agcd_pkg::hdr_t h, logic [63:0] pl);
		hist_hdr[hist_wp] = h;
		hist_pl[hist_wp] = pl;
		hist_sent[hist_wp] = now_q;
		hist_acked[hist_wp] = 1'b0;
		hist_wp = hist_wp + 4'd1;
		if (hist_count < 16) hist_count++;
		add_result(agcd_pkg::ST_TX, h, pl, 32'd0);
	endfunction

	function automatic void release_waiting();
		if (wq_count == 0 || !newest_clear()) return;
		send_frame(wq_hdr[wq_head], wq_pl[wq_head]);
		wq_head = wq_head + 8'd1;
		wq_count--;
	endfunction

	function automatic void predict_dispatch(logic [1:0] k, agcd_pkg::hdr_t h,
			logic [63:0] pl, logic [31:0] tn);
		logic [63:0] m;
		logic [3:0] i;
		bit found;
		step_results.delete();
		if (k == agcd_pkg::KIND_CMD) begin
			if (wq_count == 0 && newest_clear()) begin
				send_frame(h, pl);
			end else if (wq_count < 256) begin
				wq_hdr[wq_head + 8'(wq_count)] = h;
				wq_pl[wq_head + 8'(wq_count)] = pl;
				wq_count++;
			end else begin
				add_result(agcd_pkg::ST_DROP, h, pl, 32'd0);
			end
		end else if (k == agcd_pkg::KIND_RESP) begin
			m = (h.length >= 4'd8) ? '1 : ((64'd1 << (8 * h.length)) - 64'd1);
			found = 1'b0;
			for (int j = 0; j < hist_count && !found; j++) begin
				i = hist_wp - 4'd1 - 4'(j);
				if (!hist_acked[i] && hist_hdr[i] == h && ((hist_pl[i] ^ pl) & m) == 0) begin
					hist_acked[i] = 1'b1;
					add_result(agcd_pkg::ST_ACK, h, pl, now_q - hist_sent[i]);
					found = 1'b1;
				end
			end
			if (found) release_waiting();
			else add_result(agcd_pkg::ST_NOMATCH, h, pl, 32'd0);
		end else if (k == agcd_pkg::KIND_TICK) begin
			now_q = tn;
			release_waiting();
		end
		if (step_results.size() > 0) step_results[step_results.size() - 1].lst = 1'b1;
		foreach (step_results[n]) expected_results.push_back(step_results[n]);
	endfunction

	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d cmd %h", status, tx_command);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st || tx_command !== e.cmd || tx_length !== e.len ||
						tx_payload !== e.pl || ack_latency !== e.lat || last !== e.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st %0d cmd %h len %0d pl %h lat %0d last %b,",
							" got st %0d cmd %h len %0d pl %h lat %0d last %b"},
							e.st, e.cmd, e.len, e.pl, e.lat, e.lst,
							status, tx_command, tx_length, tx_payload, ack_latency, last);
				end
			end
		end
	end

	// one transaction; start is left high so a burst can follow
	task automatic send_item(logic [1:0] k, logic [7:0] c, logic [3:0] l,
			logic [63:0] p, logic [31:0] t);
		agcd_pkg::hdr_t h;
		h.command = c;
		h.length = l;
		start <= 1'b1;
		kind <= k;
		command <= c;
		length <= l;
		payload <= p;
		tick_now <= t;
		do @(posedge clk); while (busy);
		predict_dispatch(k, h, p, t);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_idle();
		pause(1);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_timeout(logic [7:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_q = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// echo of the newest transmitted frame
	task automatic ack_newest();
		logic [3:0] i;
		i = hist_wp - 4'd1;
		send_item(agcd_pkg::KIND_RESP, hist_hdr[i].command, hist_hdr[i].length, hist_pl[i],
			32'd0);
	endtask

	task automatic test_directed();
		send_item(agcd_pkg::KIND_CMD, 8'hFF, 4'd8, '1, 32'd0);
		send_item(agcd_pkg::KIND_CMD, 8'h00, 4'd0, 64'd0, 32'd0);
		send_item(agcd_pkg::KIND_CMD, 8'h5A, 4'd15, rand64(), 32'd0);
		send_item(agcd_pkg::KIND_RESP, 8'hFF, 4'd8, '1, 32'd0);
		send_item(agcd_pkg::KIND_RESP, 8'h00, 4'd0, rand64(), 32'd0);
		send_item(agcd_pkg::KIND_RESP, 8'h12, 4'd3, rand64(), 32'd0);
		send_item(2'd3, 8'hAA, 4'd5, rand64(), '1);
		send_item(agcd_pkg::KIND_TICK, 8'd0, 4'd0, 64'd0, 32'hFFFF_FFF0);
		send_item(agcd_pkg::KIND_CMD, 8'h33, 4'd4, rand64(), 32'd0);
		send_item(agcd_pkg::KIND_TICK, 8'd0, 4'd0, 64'd0, 32'h0000_0005);
		ack_newest();
		send_item(agcd_pkg::KIND_TICK, 8'd0, 4'd0, 64'd0, '1);
		send_item(agcd_pkg::KIND_TICK, 8'd0, 4'd0, 64'd0, 32'd0);
		pause(3);
	endtask

	task automatic test_queue_full();
		set_timeout(8'd255);
		repeat (262) send_item(agcd_pkg::KIND_CMD, 8'($urandom), 4'($urandom_range(0, 8)),
			rand64(), 0);
		pause(2);
		while (wq_count > 0) ack_newest();
		ack_newest();
		pause(2);
	endtask

	task automatic random_item();
		int sel;
		int j;
		logic [3:0] i;
		logic [3:0] l;
		logic [63:0] p;
		sel = $urandom_range(0, 99);
		l = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		if (sel < 38) begin
			send_item(agcd_pkg::KIND_CMD, 8'($urandom_range(0, 7)), l, rand64(), 32'd0);
		end else if (sel < 75 && hist_count > 0) begin
			j = $urandom_range(0, (hist_count > 3 && $urandom_range(0, 1)) ? 3 : hist_count - 1);
			i = hist_wp - 4'd1 - 4'(j);
			p = hist_pl[i];
			if (hist_hdr[i].length < 8) p = p ^ (rand64() << (8 * hist_hdr[i].length));
			if ($urandom_range(0, 7) == 0) p = p ^ (64'd1 << $urandom_range(0, 63));
			send_item(agcd_pkg::KIND_RESP, hist_hdr[i].command, hist_hdr[i].length, p, 32'd0);
		end else if (sel < 80) begin
			send_item(agcd_pkg::KIND_RESP, 8'($urandom), l, rand64(), 32'd0);
		end else if (sel < 97) begin
			send_item(agcd_pkg::KIND_TICK, 8'($urandom), l, rand64(),
				($urandom_range(0, 15) == 0) ? $urandom : now_q + $urandom_range(0, 300));
		end else begin
			send_item(2'd3, 8'($urandom), l, rand64(), $urandom);
		end
	endtask

	task automatic test_random();
		logic [7:0] timeouts [5];
		int burst;
		timeouts = '{8'd1, 8'd255, 8'd0, 8'd10, 8'($urandom_range(2, 254))};
		foreach (timeouts[t]) begin
			set_timeout(timeouts[t]);
			for (int n = 0; n < 70; n += burst) begin
				burst = $urandom_range(1, 20);
				repeat (burst) random_item();
				if ($urandom_range(0, 9) == 0) wait_idle();
				else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 15));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = agcd_pkg::KIND_CMD;
		command = '0;
		length = '0;
		payload = '0;
		tick_now = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		timeout_q = agcd_pkg::TIMEOUT_RESET;
		now_q = '0;
		wq_head = '0;
		wq_count = 0;
		hist_wp = '0;
		hist_count = 0;
		foreach (hist_acked[n]) hist_acked[n] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_queue_full();
		test_random();
		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ack_gated_command_dispatcher test passed");
		end else begin
			$display("ack_gated_command_dispatcher test failed");
		end
		$finish;
	end
endmodule
